// ===== hdl/fspsc_pkg.sv =====
// ----------------------------------------------------------------------------
// fspsc_pkg
// Shared types, fixed-point constants and the CORDIC arc table for the
// field sine perturbation scaler.
// ----------------------------------------------------------------------------
package fspsc_pkg;

  localparam int CORDIC_STEPS_DEF = 20;

  localparam int POS_W   = 24;
  localparam int FIELD_W = 24;
  localparam int AMP_W   = 16;
  localparam int FREQ_W  = 26;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 26;

  localparam int R_W     = 31;
  localparam int PHI_W   = 33;
  localparam int ARG_W   = 50;
  localparam int TERM_W  = 28;

  localparam logic signed [34:0] PI_Q30         = 35'sd3373259426;
  localparam logic signed [34:0] TWO_PI_Q30     = 35'sd6746518852;
  localparam logic signed [34:0] HALF_PI_Q30    = 35'sd1686629713;
  localparam logic signed [34:0] THREE_HALF_PI  = 35'sd5059889139;
  localparam logic signed [33:0] INV_GAIN_Q30   = 34'sd652032874;
  localparam logic        [29:0] INV_GAIN_U     = 30'd652032874;
  localparam logic signed [21:0] TWO_PI_RECIP   = 22'sd667544;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PHI_AMP  = 3'd0,
    REG_PHI_FREQ = 3'd1,
    REG_RAD_AMP  = 3'd2,
    REG_RAD_FREQ = 3'd3,
    REG_AX_AMP   = 3'd4,
    REG_AX_FREQ  = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic signed [POS_W-1:0]   pos_x;
    logic signed [POS_W-1:0]   pos_y;
    logic signed [POS_W-1:0]   pos_z;
    logic signed [FIELD_W-1:0] field_in_x;
    logic signed [FIELD_W-1:0] field_in_y;
    logic signed [FIELD_W-1:0] field_in_z;
  } in_item_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] field_out_x;
    logic signed [FIELD_W-1:0] field_out_y;
    logic signed [FIELD_W-1:0] field_out_z;
  } out_item_t;

  function automatic logic signed [33:0] arc(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h3243F6A8;
      5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;
      5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;
      5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;
      5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;
      5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd31: v = 32'd0;
      default: v = 32'd1 << (5'd30 - i);
    endcase
    return $signed({2'b00, v});
  endfunction

endpackage

// ===== hdl/fspsc_vector.sv =====
// ----------------------------------------------------------------------------
// fspsc_vector
// Pipelined vectoring CORDIC giving radius and wrapped azimuth of (x, y).
// ----------------------------------------------------------------------------
module fspsc_vector #(
  parameter int CORDIC_STEPS = fspsc_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [fspsc_pkg::POS_W-1:0]  x,
  input  logic signed [fspsc_pkg::POS_W-1:0]  y,
  output logic        [fspsc_pkg::R_W-1:0]    r,
  output logic        [fspsc_pkg::PHI_W-1:0]  phi
);
  import fspsc_pkg::*;

  logic signed [33:0] vx [0:CORDIC_STEPS];
  logic signed [33:0] vy [0:CORDIC_STEPS];
  logic signed [33:0] za [0:CORDIC_STEPS];
  logic               base [0:CORDIC_STEPS];
  logic               sp [0:CORDIC_STEPS];
  logic [R_W-1:0]     sp_r [0:CORDIC_STEPS];
  logic [PHI_W-1:0]   sp_phi [0:CORDIC_STEPS];

  logic signed [33:0] x64, y64;
  logic [POS_W:0]     ax, ay;
  logic               zx, zy;

  always_comb begin
    x64 = {{4{x[POS_W-1]}}, x, 6'd0};
    y64 = {{4{y[POS_W-1]}}, y, 6'd0};
    ax  = x[POS_W-1] ? -{x[POS_W-1], x} : {x[POS_W-1], x};
    ay  = y[POS_W-1] ? -{y[POS_W-1], y} : {y[POS_W-1], y};
    zx  = (x == '0);
    zy  = (y == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vx[0]   <= x[POS_W-1] ? -x64 : x64;
      vy[0]   <= x[POS_W-1] ? -y64 : y64;
      za[0]   <= '0;
      base[0] <= x[POS_W-1];
      sp[0]   <= zx | zy;
      if (zx && zy) begin
        sp_r[0]   <= '0;
        sp_phi[0] <= '0;
      end else if (zy) begin
        sp_r[0]   <= R_W'({ax, 6'd0});
        sp_phi[0] <= x[POS_W-1] ? PHI_W'(PI_Q30) : '0;
      end else begin
        sp_r[0]   <= R_W'({ay, 6'd0});
        sp_phi[0] <= y[POS_W-1] ? PHI_W'(THREE_HALF_PI) : PHI_W'(HALF_PI_Q30);
      end
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        if (vy[i] > 0) begin
          vx[i+1] <= vx[i] + (vy[i] >>> i);
          vy[i+1] <= vy[i] - (vx[i] >>> i);
          za[i+1] <= za[i] + arc(5'(i));
        end else begin
          vx[i+1] <= vx[i] - (vy[i] >>> i);
          vy[i+1] <= vy[i] + (vx[i] >>> i);
          za[i+1] <= za[i] - arc(5'(i));
        end
        base[i+1]   <= base[i];
        sp[i+1]     <= sp[i];
        sp_r[i+1]   <= sp_r[i];
        sp_phi[i+1] <= sp_phi[i];
      end
    end
  end

  logic [61:0]        rprod;
  logic [PHI_W-1:0]   phi_w;
  logic               sp_q;
  logic [R_W-1:0]     sp_r_q;
  logic [PHI_W-1:0]   sp_phi_q;
  logic signed [34:0] zz;
  logic [62:0]        rsum;

  always_comb begin
    zz = 35'(za[CORDIC_STEPS]) + (base[CORDIC_STEPS] ? PI_Q30 : 35'sd0);
    if (zz < 0) begin
      zz = zz + TWO_PI_Q30;
    end
    rsum = {1'b0, rprod} + 63'(64'd1 << 29);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rprod    <= 62'(vx[CORDIC_STEPS][31:0]) * 62'(INV_GAIN_U);
      phi_w    <= zz[PHI_W-1:0];
      sp_q     <= sp[CORDIC_STEPS];
      sp_r_q   <= sp_r[CORDIC_STEPS];
      sp_phi_q <= sp_phi[CORDIC_STEPS];
      r        <= sp_q ? sp_r_q : rsum[60:30];
      phi      <= sp_q ? sp_phi_q : phi_w;
    end
  end

endmodule

// ===== hdl/fspsc_sine.sv =====
// ----------------------------------------------------------------------------
// fspsc_sine
// Reduces an angle modulo 2*pi, runs a pipelined rotation CORDIC and forms
// the Q24 perturbation term 1 + amp*sin(angle).
// ----------------------------------------------------------------------------
module fspsc_sine #(
  parameter int CORDIC_STEPS = fspsc_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [fspsc_pkg::ARG_W-1:0]   arg,
  input  logic signed [fspsc_pkg::AMP_W-1:0]   amp,
  output logic signed [fspsc_pkg::TERM_W-1:0]  term
);
  import fspsc_pkg::*;

  logic signed [51:0]      qp;
  logic signed [ARG_W-1:0] arg1, arg2;
  logic signed [54:0]      qc;
  logic [PHI_W-1:0]        ang;
  logic signed [29:0]      t;
  logic signed [19:0]      q;
  logic signed [54:0]      diff;
  logic signed [36:0]      m, mp, mm;

  always_comb begin
    t    = arg[ARG_W-1:20];
    q    = qp[51:32];
    diff = 55'(arg2) - qc;
    m    = diff[36:0];
    mp   = m + 37'(TWO_PI_Q30);
    mm   = m - 37'(TWO_PI_Q30);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qp   <= 52'(t) * 52'(TWO_PI_RECIP);
      arg1 <= arg;
      qc   <= 55'(q) * 55'(TWO_PI_Q30);
      arg2 <= arg1;
      if (m < 0) begin
        ang <= mp[PHI_W-1:0];
      end else if (m >= 37'(TWO_PI_Q30)) begin
        ang <= mm[PHI_W-1:0];
      end else begin
        ang <= m[PHI_W-1:0];
      end
    end
  end

  logic signed [33:0] cx [0:CORDIC_STEPS];
  logic signed [33:0] cy [0:CORDIC_STEPS];
  logic signed [33:0] cz [0:CORDIC_STEPS];
  logic signed [34:0] fa;

  always_comb begin
    fa = $signed({2'b00, ang});
    if (fa > PI_Q30) begin
      fa = fa - TWO_PI_Q30;
    end
    if (fa > HALF_PI_Q30) begin
      fa = PI_Q30 - fa;
    end else if (fa < -HALF_PI_Q30) begin
      fa = -PI_Q30 - fa;
    end
  end

  assign cx[0] = INV_GAIN_Q30;
  assign cy[0] = '0;

  always_ff @(posedge clk) begin
    if (en) begin
      cz[0] <= fa[33:0];
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        if (cz[i] >= 0) begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          cz[i+1] <= cz[i] - arc(5'(i));
        end else begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          cz[i+1] <= cz[i] + arc(5'(i));
        end
      end
    end
  end

  logic signed [31:0] s;
  logic signed [47:0] ap;
  logic signed [48:0] apr;

  always_comb begin
    if (cy[CORDIC_STEPS] > 34'sd1073741824) begin
      s = 32'sd1073741824;
    end else if (cy[CORDIC_STEPS] < -34'sd1073741824) begin
      s = -32'sd1073741824;
    end else begin
      s = cy[CORDIC_STEPS][31:0];
    end
    apr = 49'(ap) + 49'sd524288;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ap   <= 48'(amp) * 48'(s);
      term <= TERM_W'(29'sd16777216 + apr[48:20]);
    end
  end

endmodule

// ===== hdl/field_sine_perturbation_scale_top.sv =====
// ----------------------------------------------------------------------------
// field_sine_perturbation_scale_top
// Scales a magnetic field vector by a product of three sine perturbations
// of azimuth, radius and axial position.
// ----------------------------------------------------------------------------
// The block is a fully pipelined datapath that takes one transaction per
// clock while the output is not stalled and returns one result for each,
// in order. The result is formed by the vectoring CORDIC for radius and
// azimuth followed by the rotation CORDICs for the three sines, one stage
// per iteration. A stalled output freezes the whole pipeline, so input
// stall follows output stall while a result is held. Registers may be
// written only while no transaction is in flight.
module field_sine_perturbation_scale_top #(
  parameter int CORDIC_STEPS = fspsc_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  fspsc_pkg::in_item_t                    in_data,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output fspsc_pkg::out_item_t                   out_data,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [fspsc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [fspsc_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import fspsc_pkg::*;

  localparam int LV    = CORDIC_STEPS + 3;
  localparam int LS    = CORDIC_STEPS + 6;
  localparam int DP_N  = LV + LS + 5;
  localparam int VLD_N = LV + LS + 7;

  logic signed [AMP_W-1:0] phi_amp, rad_amp, ax_amp;
  logic [FREQ_W-1:0]       phi_freq, rad_freq, ax_freq;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phi_amp  <= '0;
      phi_freq <= 26'd8388608;
      rad_amp  <= '0;
      rad_freq <= 26'd810875;
      ax_amp   <= '0;
      ax_freq  <= 26'd2635341;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_PHI_AMP:  phi_amp  <= cfg_data[AMP_W-1:0];
        REG_PHI_FREQ: phi_freq <= cfg_data;
        REG_RAD_AMP:  rad_amp  <= cfg_data[AMP_W-1:0];
        REG_RAD_FREQ: rad_freq <= cfg_data;
        REG_AX_AMP:   ax_amp   <= cfg_data[AMP_W-1:0];
        REG_AX_FREQ:  ax_freq  <= cfg_data;
        default: ;
      endcase
    end
  end

  logic             en;
  logic [VLD_N-1:0] vld;
  in_item_t         dp [0:DP_N-1];

  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign out_valid = vld[VLD_N-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[VLD_N-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dp[0] <= in_data;
    end
  end

  for (genvar k = 1; k < DP_N; k++) begin : g_dly
    always_ff @(posedge clk) begin
      if (en) begin
        dp[k] <= dp[k-1];
      end
    end
  end

  logic [R_W-1:0]   r;
  logic [PHI_W-1:0] phi;

  fspsc_vector #(.CORDIC_STEPS(CORDIC_STEPS)) u_vector (
    .clk (clk),
    .en  (en),
    .x   (dp[0].pos_x),
    .y   (dp[0].pos_y),
    .r   (r),
    .phi (phi)
  );

  logic [58:0]        p1;
  logic [56:0]        p2;
  logic signed [50:0] p3;
  logic [59:0]        s1;
  logic [57:0]        s2;
  logic signed [51:0] s3;
  logic signed [ARG_W-1:0] a1, a2, a3;

  always_comb begin
    s1 = {1'b0, p1} + 60'(64'd1 << 23);
    s2 = {1'b0, p2} + 58'd128;
    s3 = 52'(p3) + 52'sd2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1 <= 59'(phi_freq) * 59'(phi);
      p2 <= 57'(rad_freq) * 57'(r);
      p3 <= $signed({25'd0, ax_freq}) * 51'(dp[LV].pos_z);
      a1 <= $signed({14'd0, s1[59:24]});
      a2 <= $signed(s2[57:8]);
      a3 <= s3[51:2];
    end
  end

  logic signed [TERM_W-1:0] t1, t2, t3;

  fspsc_sine #(.CORDIC_STEPS(CORDIC_STEPS)) u_sine_phi (
    .clk (clk), .en (en), .arg (a1), .amp (phi_amp), .term (t1)
  );

  fspsc_sine #(.CORDIC_STEPS(CORDIC_STEPS)) u_sine_rad (
    .clk (clk), .en (en), .arg (a2), .amp (rad_amp), .term (t2)
  );

  fspsc_sine #(.CORDIC_STEPS(CORDIC_STEPS)) u_sine_ax (
    .clk (clk), .en (en), .arg (a3), .amp (ax_amp), .term (t3)
  );

  logic signed [55:0] f12;
  logic signed [TERM_W-1:0] t3d;
  logic signed [57:0] f123;
  logic signed [56:0] f12s;
  logic signed [58:0] f123s;
  logic signed [29:0] f12r, fr;
  logic signed [53:0] px, py, pz;

  always_comb begin
    f12s  = 57'(f12) + 57'sd8388608;
    f12r  = f12s[53:24];
    f123s = 59'(f123) + 59'sd8388608;
    fr    = f123s[53:24];
  end

  function automatic logic signed [FIELD_W-1:0] sat(input logic signed [53:0] p);
    logic signed [54:0] v;
    logic signed [30:0] q;
    v = 55'(p) + 55'sd8388608;
    q = v[54:24];
    if (q > 31'sd8388607) begin
      return 24'sd8388607;
    end else if (q < -31'sd8388608) begin
      return -24'sd8388608;
    end
    return q[FIELD_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      f12  <= 56'(t1) * 56'(t2);
      t3d  <= t3;
      f123 <= 58'(f12r) * 58'(t3d);
      px   <= 54'(dp[LV+LS+4].field_in_x) * 54'(fr);
      py   <= 54'(dp[LV+LS+4].field_in_y) * 54'(fr);
      pz   <= 54'(dp[LV+LS+4].field_in_z) * 54'(fr);
      out_data.field_out_x <= sat(px);
      out_data.field_out_y <= sat(py);
      out_data.field_out_z <= sat(pz);
    end
  end

  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  a_freeze: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("valid bits moved while the pipeline was stalled");

  a_shift: assert property (@(posedge clk) disable iff (rst)
    en |=> vld[VLD_N-1] == $past(vld[VLD_N-2]))
    else $error("valid bit lost or repeated in the pipeline");

endmodule
